>>> rtl/pepc_pkg.sv
package pepc_pkg;

    // Stream payload widths; the tdata widths are padded to whole bytes.
    localparam int unsigned IN_TDATA_W  = 264;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 200;
    localparam int unsigned OUT_TUSER_W = 3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUORUM_SIZE  = 2'd0,
        CFG_OWN_PROPOSAL = 2'd1,
        CFG_LOG_POSITION = 2'd2
    } t_cfg_idx;

    // Response kind codes as they arrive on the input stream.
    typedef enum logic [1:0] {
        KIND_ACCEPT  = 2'd0,
        KIND_REJECT  = 2'd1,
        KIND_IGNORED = 2'd2
    } t_kind;

    // Command codes.
    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    // Result verdicts.
    typedef enum logic [2:0] {
        VERD_ACCEPT  = 3'd0,
        VERD_REJECT  = 3'd1,
        VERD_IGNORED = 3'd2,
        VERD_LEARNED = 3'd3,
        VERD_ERROR   = 3'd4
    } t_verdict;

    // Operation class decided by the front end.
    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_BAD_KIND = 3'd1,
        OP_IGNORE   = 3'd2,
        OP_REJECT   = 3'd3,
        OP_ACC_OK   = 3'd4,
        OP_ACC_BAD  = 3'd5
    } t_op;

    // Classified item travelling through the queue.
    typedef struct packed {
        t_op         op;
        logic [63:0] proposal;
        logic        act_present;
        logic        learned;
        logic        has_perf;
        logic [63:0] performed;
        logic [63:0] handle;
    } t_item;

    // One result beat.
    typedef struct packed {
        t_verdict    verdict;
        logic [63:0] nack_proposal;
        logic        act_present;
        logic [63:0] handle;
        logic [63:0] performed;
    } t_result;

endpackage

>>> rtl/pepc_front.sv
module pepc_front (
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pepc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [pepc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic [63:0]                         i_own_proposal,
    input  logic [63:0]                         i_log_position,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output pepc_pkg::t_item                     o_item
);

    logic        cmd;
    logic [1:0]  kind;
    logic [63:0] resp_position;
    logic        mismatch;

    assign cmd           = s_axis_tuser[0];
    assign kind          = s_axis_tuser[2:1];
    assign resp_position = s_axis_tdata[128:65];

    assign s_axis_tready = !i_queue_full;
    assign o_push        = s_axis_tvalid && !i_queue_full;

    // Proposal and position checks are done here, against configuration that the user
    // must keep fixed while items are in flight; the block does not enforce this.
    assign mismatch = (s_axis_tdata[63:0] != i_own_proposal) ||
                      (resp_position != i_log_position);

    always_comb begin
        o_item.proposal    = s_axis_tdata[63:0];
        o_item.act_present = s_axis_tdata[64];
        o_item.learned     = s_axis_tdata[129];
        o_item.has_perf    = s_axis_tdata[130];
        o_item.performed   = s_axis_tdata[194:131];
        o_item.handle      = s_axis_tdata[258:195];
        if (cmd == pepc_pkg::CMD_START) begin
            o_item.op = pepc_pkg::OP_START;
        end else begin
            unique case (kind)
                pepc_pkg::KIND_ACCEPT: begin
                    o_item.op = mismatch ? pepc_pkg::OP_ACC_BAD : pepc_pkg::OP_ACC_OK;
                end
                pepc_pkg::KIND_REJECT:  o_item.op = pepc_pkg::OP_REJECT;
                pepc_pkg::KIND_IGNORED: o_item.op = pepc_pkg::OP_IGNORE;
                default:                o_item.op = pepc_pkg::OP_BAD_KIND;
            endcase
        end
    end

endmodule

>>> rtl/pepc_fifo.sv
module pepc_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pepc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pepc_pkg::t_item o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pepc_pkg::t_item r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/pepc_back.sv
module pepc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_quorum_size,
    input  logic              i_q_valid,
    input  pepc_pkg::t_item   i_item,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output pepc_pkg::t_result o_result
);

    logic        r_done, n_done;
    logic [7:0]  r_reply_cnt, n_reply_cnt;
    logic [7:0]  r_ignore_cnt, n_ignore_cnt;
    logic        r_nack_valid, n_nack_valid;
    logic [63:0] r_nack_best, n_nack_best;
    logic        r_ack_valid, n_ack_valid;
    logic [63:0] r_ack_perf, n_ack_perf;
    logic [63:0] r_ack_handle, n_ack_handle;
    logic        r_out_valid, n_out_valid;
    pepc_pkg::t_result r_out, n_out;

    logic              emit;
    pepc_pkg::t_result res;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_done       = r_done;
        n_reply_cnt  = r_reply_cnt;
        n_ignore_cnt = r_ignore_cnt;
        n_nack_valid = r_nack_valid;
        n_nack_best  = r_nack_best;
        n_ack_valid  = r_ack_valid;
        n_ack_perf   = r_ack_perf;
        n_ack_handle = r_ack_handle;
        emit         = 1'b0;
        res          = '0;

        if (o_pop) begin
            if (i_item.op == pepc_pkg::OP_START) begin
                n_done       = 1'b0;
                n_reply_cnt  = '0;
                n_ignore_cnt = '0;
                n_nack_valid = 1'b0;
                n_nack_best  = '0;
                n_ack_valid  = 1'b0;
                n_ack_perf   = '0;
                n_ack_handle = '0;
            end else if (!r_done) begin
                unique case (i_item.op) inside
                    pepc_pkg::OP_IGNORE: begin
                        n_ignore_cnt = (r_ignore_cnt == 8'hFF) ? r_ignore_cnt
                                                               : r_ignore_cnt + 8'd1;
                        if (n_ignore_cnt >= i_quorum_size) begin
                            emit        = 1'b1;
                            res.verdict = pepc_pkg::VERD_IGNORED;
                        end
                    end
                    pepc_pkg::OP_REJECT, pepc_pkg::OP_ACC_OK, pepc_pkg::OP_ACC_BAD: begin
                        n_reply_cnt = (r_reply_cnt == 8'hFF) ? r_reply_cnt
                                                             : r_reply_cnt + 8'd1;
                        if (i_item.op == pepc_pkg::OP_REJECT) begin
                            if (!r_nack_valid || (r_nack_best < i_item.proposal)) begin
                                n_nack_valid = 1'b1;
                                n_nack_best  = i_item.proposal;
                            end
                        end else if (!r_nack_valid) begin
                            if (i_item.op == pepc_pkg::OP_ACC_BAD) begin
                                emit        = 1'b1;
                                res.verdict = pepc_pkg::VERD_ERROR;
                            end else if (i_item.act_present) begin
                                if (i_item.learned) begin
                                    emit            = 1'b1;
                                    res.verdict     = pepc_pkg::VERD_LEARNED;
                                    res.act_present = 1'b1;
                                    res.handle      = i_item.handle;
                                    res.performed   = i_item.has_perf ? i_item.performed
                                                                      : '0;
                                end else if (i_item.has_perf &&
                                             (!r_ack_valid ||
                                              (r_ack_perf < i_item.performed))) begin
                                    n_ack_valid  = 1'b1;
                                    n_ack_perf   = i_item.performed;
                                    n_ack_handle = i_item.handle;
                                end
                            end
                        end
                        if (!emit && (n_reply_cnt >= i_quorum_size)) begin
                            emit = 1'b1;
                            if (n_nack_valid) begin
                                res.verdict       = pepc_pkg::VERD_REJECT;
                                res.nack_proposal = n_nack_best;
                            end else if (n_ack_valid) begin
                                res.verdict     = pepc_pkg::VERD_ACCEPT;
                                res.act_present = 1'b1;
                                res.handle      = n_ack_handle;
                                res.performed   = n_ack_perf;
                            end else begin
                                res.verdict = pepc_pkg::VERD_ACCEPT;
                            end
                        end
                    end
                    pepc_pkg::OP_BAD_KIND: begin
                        emit        = 1'b1;
                        res.verdict = pepc_pkg::VERD_ERROR;
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
                if (emit) begin
                    n_done = 1'b1;
                end
            end
        end

        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (o_pop && emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done       <= 1'b0;
            r_reply_cnt  <= '0;
            r_ignore_cnt <= '0;
            r_nack_valid <= 1'b0;
            r_nack_best  <= '0;
            r_ack_valid  <= 1'b0;
            r_ack_perf   <= '0;
            r_ack_handle <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_done       <= n_done;
            r_reply_cnt  <= n_reply_cnt;
            r_ignore_cnt <= n_ignore_cnt;
            r_nack_valid <= n_nack_valid;
            r_nack_best  <= n_nack_best;
            r_ack_valid  <= n_ack_valid;
            r_ack_perf   <= n_ack_perf;
            r_ack_handle <= n_ack_handle;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

>>> rtl/paxos_explicit_promise_collector.sv
// Channel     Direction  Beat contents
// ---------   ---------  ---------------------------------------------------------
// s_axis      in         one command: start of round or one replica response
// m_axis      out        one round verdict (at most one per response beat)
// i_cfg_*     in         register write: quorum size, own proposal, log position
//
// The front end classifies a beat in the cycle it arrives and writes it into
// a small queue, and the back end retires one queued beat per cycle while
// the output is not stalled, updating the tallies and loading the output
// register; a beat passes the queue slot and then the output register.
// Reset is synchronous and active low; it empties the queue, clears the round
// tallies and the output valid flag, and sets the quorum size to one.
// A stalled output holds the back end, and a full queue drops s_axis_tready.
module paxos_explicit_promise_collector #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Fields from the lowest bit: resp_proposal[63:0], action present flag[64],
    // resp_position[128:65], act_learned[129], act_has_performed[130],
    // act_performed[194:131], act_handle[258:195], zero padding[263:259].
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pepc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields from the lowest bit: command[0], resp_kind[2:1].
    input  logic [pepc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,

    // Fields from the lowest bit: nack_proposal[63:0], action present flag[64],
    // out_handle[128:65], out_performed[192:129], zero padding[199:193].
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pepc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Fields from the lowest bit: verdict[2:0].
    output logic [pepc_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,

    input  logic                                i_cfg_we,
    input  logic [pepc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pepc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    // Configuration registers. The user must see that they are only written while the block is idle
    // (the block does not enforce this), so the front end may compare against them as beats arrive.
    logic [7:0]  r_quorum_size;
    logic [63:0] r_own_proposal;
    logic [63:0] r_log_position;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quorum_size  <= 8'd1;
            r_own_proposal <= '0;
            r_log_position <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pepc_pkg::CFG_QUORUM_SIZE:  r_quorum_size  <= i_cfg_wdata[7:0];
                pepc_pkg::CFG_OWN_PROPOSAL: r_own_proposal <= i_cfg_wdata;
                pepc_pkg::CFG_LOG_POSITION: r_log_position <= i_cfg_wdata;
                default: begin
                    r_quorum_size <= r_quorum_size;
                end
            endcase
        end
    end

    logic              push;
    logic              queue_full;
    pepc_pkg::t_item   front_item;
    logic              pop;
    logic              q_valid;
    pepc_pkg::t_item   q_item;
    logic              out_valid;
    pepc_pkg::t_result out_result;

    // Front end: decodes the command and response kind and checks the
    // proposal and position of accepts against the configured request.
    pepc_front u_front (
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .i_own_proposal (r_own_proposal),
        .i_log_position (r_log_position),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    // Queue of classified beats between the two halves.
    pepc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back end: keeps the round tallies, decides the verdict and holds the
    // output register.
    pepc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_quorum_size (r_quorum_size),
        .i_q_valid     (q_valid),
        .i_item        (q_item),
        .o_pop         (pop),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (out_valid),
        .o_result      (out_result)
    );

    assign m_axis_tvalid          = out_valid;
    assign m_axis_tuser           = out_result.verdict;
    assign m_axis_tdata[63:0]     = out_result.nack_proposal;
    assign m_axis_tdata[64]       = out_result.act_present;
    assign m_axis_tdata[128:65]   = out_result.handle;
    assign m_axis_tdata[192:129]  = out_result.performed;
    assign m_axis_tdata[199:193]  = '0;

    // The cycle after reset no verdict beat is offered.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict beat offered right after reset");

    // Only accept and learned verdicts return an action handle.
    a_action_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[64]) |->
        (m_axis_tuser == pepc_pkg::VERD_ACCEPT || m_axis_tuser == pepc_pkg::VERD_LEARNED))
        else $error("action handle returned with a verdict that carries none");

    // A nonzero nack proposal is only reported with a reject verdict.
    a_nack_only_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[63:0] != 64'd0)) |->
        (m_axis_tuser == pepc_pkg::VERD_REJECT))
        else $error("nack proposal reported without a reject verdict");

    // The queue is never pushed while it reports full.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_full |-> !push)
        else $error("push into a full queue");

endmodule
